/* rtl/msweep_pkg.sv */
package msweep_pkg;

    // Matrix geometry and number format
    localparam int MAX_ORDER = 16;
    localparam int FRAC_BITS = 24;
    localparam int WORD_W    = 48;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int CNT_W     = $clog2(MAX_ORDER + 1);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
    localparam int ORDER_W   = 5;
    localparam int THR_W     = 47;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 47;

    localparam logic [WORD_W-1:0] QMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] QMIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SWEEP = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Reply kinds
    localparam logic REPLY_STATUS = 1'b0;
    localparam logic REPLY_READ   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

    typedef struct packed {
        logic [1:0]               kind;
        logic [3:0]               row;
        logic [3:0]               col;
        logic signed [WORD_W-1:0] value;
        logic [3:0]               pivot;
        logic                     last_pivot;
    } item_t;

    typedef struct packed {
        logic                     reply_kind;
        logic signed [WORD_W-1:0] read_value;
        logic                     pivot_error;
        logic                     list_done;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } div_rsp_t;

    // Magnitude of a two's complement word; the most negative value maps to 2^47
    function automatic logic [WORD_W-1:0] magn(input logic [WORD_W-1:0] x);
        magn = x[WORD_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

/* rtl/matrix_sweep_engine_core.sv */
// Matrix sweep engine: element store in one 256x48 RAM, sweep run by a sequencer.
// Write: stored in the RAM when accepted. Read: via the RAM read and pending registers
// to the result register. Sweep time is set by the bit-serial divider and the
// partial-product multiplier. One item at a time.
// Reset returns control, the error flag and the configuration registers to their defaults; the matrix is not cleared.
module matrix_sweep_engine_core
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_ready,
    input  msweep_pkg::item_t                       item,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output msweep_pkg::result_t                     result,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [msweep_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [msweep_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int W     = msweep_pkg::WORD_W;
    localparam int IW    = msweep_pkg::IDX_W;
    localparam int CW    = msweep_pkg::CNT_W;
    localparam int AW    = msweep_pkg::ADDR_W;
    localparam int HW    = W / 2;
    localparam int PW    = 2 * W;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_RD_WAIT  = 13'b0000000000010,
        ST_D_WAIT   = 13'b0000000000100,
        ST_PR_LD    = 13'b0000000001000,
        ST_PR_DIV   = 13'b0000000010000,
        ST_ROW      = 13'b0000000100000,
        ST_B_WAIT   = 13'b0000001000000,
        ST_EL_LD    = 13'b0000010000000,
        ST_EL_MUL   = 13'b0000100000000,
        ST_EL_SAT   = 13'b0001000000000,
        ST_EL_SUB   = 13'b0010000000000,
        ST_COL_DIV  = 13'b0100000000000,
        ST_DIAG_DIV = 13'b1000000000000
    } state_t;

    // Pending flag for a finished result that has not yet entered the output register
    logic out_wait_reg, out_wait_next;

    state_t state_reg, state_next;

    // Matrix RAM
    logic [W-1:0] mem [msweep_pkg::DEPTH];
    logic          we;
    logic [AW-1:0] waddr, ra_addr, rb_addr;
    logic [W-1:0]  wdata, rd_a_reg, rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[ra_addr];
        rd_b_reg <= mem[rb_addr];
    end

    // Configuration
    logic [msweep_pkg::ORDER_W-1:0] order_reg, order_next;
    logic [msweep_pkg::THR_W-1:0]   thr_reg, thr_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        order_next = order_reg;
        thr_next   = thr_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                msweep_pkg::CFG_ORDER:     order_next = cfg_data[msweep_pkg::ORDER_W-1:0];
                msweep_pkg::CFG_THRESHOLD: thr_next   = cfg_data[msweep_pkg::THR_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Divider
    msweep_pkg::div_req_t div_req;
    msweep_pkg::div_rsp_t div_rsp;

    msweep_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer registers
    logic [IW-1:0] p_reg, p_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  c_reg, c_next;
    logic [W-1:0]  ma_reg, ma_next;
    logic [W-1:0]  mb_reg, mb_next;
    logic          mneg_reg, mneg_next;
    logic [1:0]    k_reg, k_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [W-1:0]  prod_reg, prod_next;
    logic          last_reg, last_next;
    logic          sticky_reg, sticky_next;
    logic          inrange_reg, inrange_next;
    msweep_pkg::result_t pend_reg, pend_next;
    msweep_pkg::result_t res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic          accept;
    logic [CW-1:0] n_eff;
    logic          item_inrange;
    logic [HW-1:0] pa, pb;
    logic [PW-1:0] pp;
    logic [PW-1:0] pshift, plim;
    logic [W-1:0]  pmag;
    logic [W:0]    diff;
    logic [W-1:0]  sub_val, neg_quot;
    logic          finish;
    logic          refused;

    assign item_ready   = (state_reg == ST_IDLE) && !out_wait_reg;
    assign accept       = item_valid && item_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Order in use and element range
    always_comb
    begin
        if (order_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(order_reg) > msweep_pkg::MAX_ORDER)
        begin
            n_eff = CW'(msweep_pkg::MAX_ORDER);
        end
        else
        begin
            n_eff = CW'(order_reg);
        end
        item_inrange = (32'(item.row) < msweep_pkg::MAX_ORDER)
                    && (32'(item.col) < msweep_pkg::MAX_ORDER);
    end

    // Datapath helpers: partial product, product saturation, saturated subtract
    always_comb
    begin
        pa = k_reg[1] ? ma_reg[W-1:HW] : ma_reg[HW-1:0];
        pb = k_reg[0] ? mb_reg[W-1:HW] : mb_reg[HW-1:0];
        pp = PW'(pa * pb) << (HW * (32'(k_reg[1]) + 32'(k_reg[0])));
        pshift = acc_reg >> msweep_pkg::FRAC_BITS;
        plim   = PW'(mneg_reg ? msweep_pkg::QMIN : msweep_pkg::QMAX);
        pmag   = (pshift > plim) ? plim[W-1:0] : pshift[W-1:0];
        diff   = {c_reg[W-1], c_reg} - {prod_reg[W-1], prod_reg};
        if (diff[W] != diff[W-1])
        begin
            sub_val = diff[W] ? msweep_pkg::QMIN : msweep_pkg::QMAX;
        end
        else
        begin
            sub_val = diff[W-1:0];
        end
        neg_quot = (div_rsp.quot == msweep_pkg::QMIN) ? msweep_pkg::QMAX
                                                      : (~div_rsp.quot + 1'b1);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_wait_next  = out_wait_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        d_next         = d_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        mneg_next      = mneg_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        last_next      = last_reg;
        sticky_next    = sticky_reg;
        inrange_next   = inrange_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        ra_addr        = '0;
        rb_addr        = '0;
        div_req        = '0;
        finish         = 1'b0;
        refused        = 1'b0;

        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.kind)
                        msweep_pkg::KIND_WRITE:
                        begin
                            we    = item_inrange;
                            waddr = {IW'(item.row), IW'(item.col)};
                            wdata = item.value;
                        end
                        msweep_pkg::KIND_READ:
                        begin
                            ra_addr      = {IW'(item.row), IW'(item.col)};
                            inrange_next = item_inrange;
                            state_next   = ST_RD_WAIT;
                        end
                        msweep_pkg::KIND_SWEEP:
                        begin
                            last_next = item.last_pivot;
                            p_next    = IW'(item.pivot);
                            n_next    = n_eff;
                            if (sticky_reg)
                            begin
                                finish = 1'b1;
                            end
                            else if (32'(item.pivot) >= 32'(n_eff))
                            begin
                                finish  = 1'b1;
                                refused = 1'b1;
                            end
                            else
                            begin
                                ra_addr    = {IW'(item.pivot), IW'(item.pivot)};
                                state_next = ST_D_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                pend_next.reply_kind  = msweep_pkg::REPLY_READ;
                pend_next.read_value  = inrange_reg ? rd_a_reg : '0;
                pend_next.pivot_error = 1'b0;
                pend_next.list_done   = 1'b0;
                out_wait_next         = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_D_WAIT:
            begin
                d_next = rd_a_reg;
                if (msweep_pkg::magn(rd_a_reg) <= {1'b0, thr_reg})
                begin
                    finish  = 1'b1;
                    refused = 1'b1;
                end
                else
                begin
                    j_next     = '0;
                    ra_addr    = {p_reg, IW'(0)};
                    state_next = ST_PR_LD;
                end
            end
            // Pivot row divided by d
            ST_PR_LD:
            begin
                div_req.start = 1'b1;
                div_req.num   = rd_a_reg;
                div_req.den   = d_reg;
                state_next    = ST_PR_DIV;
            end
            ST_PR_DIV:
            begin
                if (div_rsp.done)
                begin
                    we    = 1'b1;
                    waddr = {p_reg, j_reg[IW-1:0]};
                    wdata = div_rsp.quot;
                    if (j_reg + 1'b1 < n_reg)
                    begin
                        j_next     = j_reg + 1'b1;
                        ra_addr    = {p_reg, IW'(j_reg + 1'b1)};
                        state_next = ST_PR_LD;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = ST_ROW;
                    end
                end
            end
            // Row loop over the other rows
            ST_ROW:
            begin
                if (i_reg == n_reg)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = W'(1) << msweep_pkg::FRAC_BITS;
                    div_req.den   = d_reg;
                    state_next    = ST_DIAG_DIV;
                end
                else if (i_reg[IW-1:0] == p_reg)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    ra_addr    = {i_reg[IW-1:0], p_reg};
                    j_next     = '0;
                    state_next = ST_B_WAIT;
                end
            end
            ST_B_WAIT:
            begin
                b_next     = rd_a_reg;
                ra_addr    = {p_reg, IW'(0)};
                rb_addr    = {i_reg[IW-1:0], IW'(0)};
                state_next = ST_EL_LD;
            end
            ST_EL_LD:
            begin
                c_next     = rd_b_reg;
                ma_next    = msweep_pkg::magn(b_reg);
                mb_next    = msweep_pkg::magn(rd_a_reg);
                mneg_next  = b_reg[W-1] ^ rd_a_reg[W-1];
                acc_next   = '0;
                k_next     = '0;
                state_next = ST_EL_MUL;
            end
            ST_EL_MUL:
            begin
                acc_next = acc_reg + pp;
                k_next   = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_EL_SAT;
                end
            end
            ST_EL_SAT:
            begin
                prod_next  = mneg_reg ? (~pmag + 1'b1) : pmag;
                state_next = ST_EL_SUB;
            end
            ST_EL_SUB:
            begin
                we    = 1'b1;
                waddr = {i_reg[IW-1:0], j_reg[IW-1:0]};
                wdata = sub_val;
                if (j_reg + 1'b1 < n_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    ra_addr    = {p_reg, IW'(j_reg + 1'b1)};
                    rb_addr    = {i_reg[IW-1:0], IW'(j_reg + 1'b1)};
                    state_next = ST_EL_LD;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = b_reg;
                    div_req.den   = d_reg;
                    state_next    = ST_COL_DIV;
                end
            end
            // Pivot column entry becomes -b/d
            ST_COL_DIV:
            begin
                if (div_rsp.done)
                begin
                    we         = 1'b1;
                    waddr      = {i_reg[IW-1:0], p_reg};
                    wdata      = neg_quot;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_DIAG_DIV:
            begin
                if (div_rsp.done)
                begin
                    we     = 1'b1;
                    waddr  = {p_reg, p_reg};
                    wdata  = div_rsp.quot;
                    finish = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Sweep status and sticky error
        if (finish)
        begin
            pend_next.reply_kind  = msweep_pkg::REPLY_STATUS;
            pend_next.read_value  = '0;
            pend_next.pivot_error = sticky_reg | refused;
            pend_next.list_done   = last_next;
            sticky_next           = last_next ? 1'b0 : (sticky_reg | refused);
            out_wait_next         = 1'b1;
            state_next            = ST_IDLE;
        end

        // Move a finished result into the output register
        if (out_wait_reg && (!res_valid_reg || result_ready))
        begin
            res_next       = pend_reg;
            res_valid_next = 1'b1;
            out_wait_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_wait_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            sticky_reg    <= 1'b0;
            order_reg     <= msweep_pkg::ORDER_W'(msweep_pkg::MAX_ORDER);
            thr_reg       <= msweep_pkg::THR_W'(1);
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_wait_reg  <= out_wait_next;
            res_valid_reg <= res_valid_next;
            sticky_reg    <= sticky_next;
            order_reg     <= order_next;
            thr_reg       <= thr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        mneg_reg    <= mneg_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        last_reg    <= last_next;
        inrange_reg <= inrange_next;
        pend_reg    <= pend_next;
        res_reg     <= res_next;
    end

endmodule

/* rtl/msweep_div.sv */
// Fixed-point divider: sat(trunc(num * 2^FRAC_BITS / den)), one quotient bit per cycle
module msweep_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  msweep_pkg::div_req_t req,
    output msweep_pkg::div_rsp_t rsp
);

    localparam int W     = msweep_pkg::WORD_W;
    localparam int NUM_W = msweep_pkg::WORD_W + msweep_pkg::FRAC_BITS;
    localparam int CW    = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic             neg_reg, neg_next;

    logic [W:0]   trial;
    logic         fits;
    logic [W-1:0] lim;
    logic [W-1:0] mag;

    // One restoring step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, num_reg[NUM_W-1]};
        fits      = trial >= {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W);
            num_next  = {msweep_pkg::magn(req.num), {msweep_pkg::FRAC_BITS{1'b0}}};
            den_next  = msweep_pkg::magn(req.den);
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            neg_next  = req.num[W-1] ^ req.den[W-1];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? W'(trial - {1'b0, den_reg}) : trial[W-1:0];
            q_next   = {q_reg[W-2:0], fits};
            ovf_next = ovf_reg | q_reg[W-1];
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    // Saturate and apply sign
    always_comb
    begin
        lim = neg_reg ? msweep_pkg::QMIN : msweep_pkg::QMAX;
        mag = (ovf_reg || (q_reg > lim)) ? lim : q_reg;
        rsp.done = done_reg;
        rsp.quot = neg_reg ? (~mag + 1'b1) : mag;
    end

endmodule

/* tb/tb_matrix_sweep_engine_core.sv */
module tb_matrix_sweep_engine_core;
    import msweep_pkg::*;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         LIMIT       = 2000000;
    localparam int         ITEM_GOAL   = 950;

    // Shadow of the engine: element store, sticky error, registers, pending replies
    class sweep_scoreboard;
        word_t      mat [0:DEPTH-1];
        bit         err_flag;
        logic [4:0] order_reg;
        logic [THR_W-1:0] thr_reg;
        result_t    reply_q [$];
        int         fails;
        int         sweeps;
        int         refusals;
        int         reads;

        function new();
            foreach (mat[i]) mat[i] = '0;
            err_flag  = 0;
            order_reg = 5'd16;
            thr_reg   = THR_W'(1);
            fails     = 0;
            sweeps    = 0;
            refusals  = 0;
            reads     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ORDER)
                order_reg = data[ORDER_W-1:0];
            else if (idx == CFG_THRESHOLD)
                thr_reg = data[THR_W-1:0];
        endfunction

        function logic [WORD_W-1:0] abs_word(word_t x);
            return x[WORD_W-1] ? -x : x;
        endfunction

        // Saturate a magnitude with a sign into the word range
        function word_t clamp_word(logic [95:0] m, bit neg);
            logic [95:0] lim;
            lim = neg ? (96'd1 << 47) : ((96'd1 << 47) - 96'd1);
            if (m > lim)
                m = lim;
            return neg ? word_t'(-m[WORD_W-1:0]) : word_t'(m[WORD_W-1:0]);
        endfunction

        function word_t fx_div(word_t a, word_t d);
            logic [95:0] ua;
            logic [95:0] ud;
            logic [95:0] q;
            bit          neg;
            neg = a[WORD_W-1] ^ d[WORD_W-1];
            ua  = 96'(abs_word(a));
            ud  = 96'(abs_word(d));
            if (ud == 0)
                return neg ? word_t'(QMIN) : word_t'(QMAX);
            q = (ua << FRAC_BITS) / ud;
            return clamp_word(q, neg);
        endfunction

        function word_t fx_mul(word_t a, word_t b);
            logic [95:0] ua;
            logic [95:0] ub;
            bit          neg;
            neg = a[WORD_W-1] ^ b[WORD_W-1];
            ua  = 96'(abs_word(a));
            ub  = 96'(abs_word(b));
            return clamp_word((ua * ub) >> FRAC_BITS, neg);
        endfunction

        function word_t fx_sub(word_t a, word_t b);
            logic signed [WORD_W:0] r;
            r = {a[WORD_W-1], a} - {b[WORD_W-1], b};
            if (!r[WORD_W] && r[WORD_W-1])
                return word_t'(QMAX);
            if (r[WORD_W] && !r[WORD_W-1])
                return word_t'(QMIN);
            return r[WORD_W-1:0];
        endfunction

        // One pivot step in place; returns 1 when the pivot is refused
        function bit sweep_refused(int p, int n);
            word_t d;
            word_t b;
            word_t q;
            if (p >= n)
                return 1;
            d = mat[p*MAX_ORDER + p];
            if (abs_word(d) <= {1'b0, thr_reg})
                return 1;
            for (int j = 0; j < n; j++)
                mat[p*MAX_ORDER + j] = fx_div(mat[p*MAX_ORDER + j], d);
            for (int i = 0; i < n; i++)
            begin
                if (i == p)
                    continue;
                b = mat[i*MAX_ORDER + p];
                for (int j = 0; j < n; j++)
                    mat[i*MAX_ORDER + j] = fx_sub(mat[i*MAX_ORDER + j],
                                                  fx_mul(b, mat[p*MAX_ORDER + j]));
                q = fx_div(b, d);
                mat[i*MAX_ORDER + p] = (q == word_t'(QMIN)) ? word_t'(QMAX) : -q;
            end
            mat[p*MAX_ORDER + p] = fx_div(word_t'(48'd1 << FRAC_BITS), d);
            return 0;
        endfunction

        // Accepted input transfer: update shadow state, queue the reply it causes
        function void note_item(item_t it);
            result_t r;
            int      n;
            r = '0;
            case (it.kind)
                KIND_WRITE: mat[{it.row, it.col}] = it.value;
                KIND_READ:
                begin
                    r.reply_kind = REPLY_READ;
                    r.read_value = mat[{it.row, it.col}];
                    reply_q.push_back(r);
                    reads++;
                end
                KIND_SWEEP:
                begin
                    n = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
                    if (!err_flag && sweep_refused(int'(it.pivot), n))
                        err_flag = 1;
                    r.reply_kind  = REPLY_STATUS;
                    r.pivot_error = err_flag;
                    r.list_done   = it.last_pivot;
                    reply_q.push_back(r);
                    sweeps++;
                    if (err_flag)
                        refusals++;
                    if (it.last_pivot)
                        err_flag = 0;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("ERROR @%0t: %s", $time, what);
            fails++;
        endtask

        // Result transfer: compare against the oldest pending reply
        task check_result(result_t got);
            result_t want;
            if (reply_q.size() == 0)
            begin
                report_mismatch("result with no pending reply");
                return;
            end
            want = reply_q.pop_front();
            if (got.reply_kind !== want.reply_kind)
                report_mismatch($sformatf("reply_kind %0b, want %0b",
                                          got.reply_kind, want.reply_kind));
            if (got.read_value !== want.read_value)
                report_mismatch($sformatf("read_value %h, want %h",
                                          got.read_value, want.read_value));
            if (got.pivot_error !== want.pivot_error)
                report_mismatch($sformatf("pivot_error %0b, want %0b",
                                          got.pivot_error, want.pivot_error));
            if (got.list_done !== want.list_done)
                report_mismatch($sformatf("list_done %0b, want %0b",
                                          got.list_done, want.list_done));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sweep_scoreboard sb = new();
    bit              written [0:DEPTH-1];
    bit              idle_on;
    int              item_count;
    int              phase_count;
    int              cycles;

    matrix_sweep_engine_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("matrix_sweep_engine_core: mismatch");
            $finish;
        end
    end

    // Result side: random stalls after each transfer while idle_on is set
    initial
    begin
        int hold;
        hold = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                sb.check_result(result);
                hold = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (hold > 0)
            begin
                hold--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    function automatic item_t mk(logic [1:0] kind, int row, int col, word_t value,
                                 int pivot, bit last);
        item_t it;
        it.kind       = kind;
        it.row        = row[3:0];
        it.col        = col[3:0];
        it.value      = value;
        it.pivot      = pivot[3:0];
        it.last_pivot = last;
        return it;
    endfunction

    function automatic int eff_order(int order);
        return (order == 0) ? 1 : (order > MAX_ORDER) ? MAX_ORDER : order;
    endfunction

    // Well-conditioned element: larger on the diagonal, random fraction and sign
    function automatic word_t pick_elem(bit diag);
        logic [WORD_W-1:0] m;
        m = diag ? (48'($urandom_range(1, 8)) << FRAC_BITS)
                 : (48'($urandom_range(0, 1)) << FRAC_BITS);
        m = m | 48'($urandom_range(0, 24'hFFFFFF));
        return $urandom_range(0, 1) ? -word_t'(m) : word_t'(m);
    endfunction

    // Input transfer; valid stays high across back-to-back items
    task send_item(item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        sb.note_item(it);
        if (it.kind == KIND_WRITE)
            written[{it.row, it.col}] = 1;
        if (it.kind != KIND_UNUSED)
            item_count++;
    endtask

    // Hold off until all replies are in, then let the engine settle
    task drain();
        item_valid <= 1'b0;
        while (sb.reply_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task fill_region(int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_item(mk(KIND_WRITE, r, c, pick_elem(r == c), 0, 0));
    endtask

    task read_somewhere(int n);
        int r;
        int c;
        r = $urandom_range(0, 15);
        c = $urandom_range(0, 15);
        if (!written[r*MAX_ORDER + c])
        begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
        end
        send_item(mk(KIND_READ, r, c, word_t'({$urandom, $urandom}),
                     $urandom_range(0, 15), $urandom_range(0, 1)));
    endtask

    // One configuration setting followed by mixed traffic
    task run_phase(int order, logic [THR_W-1:0] thr, int budget);
        int n;
        int start;
        int k;
        int sel;
        int p;
        bit last;
        drain();
        write_reg(CFG_ORDER, CFG_DATA_W'(order));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        n = eff_order(order);
        idle_on = (phase_count % 4) != 3;
        phase_count++;
        fill_region(n);
        start = item_count;
        while (item_count - start < budget)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                // pivot list, now and then on a fresh matrix
                if (n < 8 && $urandom_range(0, 2) == 0)
                    fill_region(n);
                k = $urandom_range(1, (n >= 8) ? 2 : 4);
                for (int i = 0; i < k; i++)
                begin
                    p = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, n - 1);
                    last = (i == k - 1) && ($urandom_range(0, 9) != 0);
                    send_item(mk(KIND_SWEEP, $urandom_range(0, 15), $urandom_range(0, 15),
                                 word_t'({$urandom, $urandom}), p, last));
                end
                repeat ($urandom_range(0, 3)) read_somewhere(n);
            end
            else if (sel < 70)
                read_somewhere(n);
            else if (sel < 80)
                send_item(mk(KIND_WRITE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                             pick_elem($urandom_range(0, 1)), $urandom_range(0, 15), 0));
            else if (sel < 90)
                send_item(mk(KIND_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                             word_t'({$urandom, $urandom}), $urandom_range(0, 15),
                             $urandom_range(0, 1)));
            else if (sel < 95)
                send_item(mk(KIND_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                             word_t'({$urandom, $urandom}), $urandom_range(0, 15),
                             $urandom_range(0, 1)));
            else
                read_somewhere(n);
        end
    endtask

    initial
    begin
        int orders [];
        logic [THR_W-1:0] thr;
        int order;
        orders     = '{0, 1, 2, 3, 4, 5, 31, 3, 16, 2, 8, 4};
        clk        = 1'b0;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_on    = 1;
        item_count = 0;
        phase_count = 0;
        cycles     = 0;
        foreach (written[i]) written[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: value extremes at the corner elements
        write_reg(CFG_ORDER, CFG_DATA_W'(2));
        send_item(mk(KIND_WRITE, 0, 0, word_t'(QMAX), 0, 0));
        send_item(mk(KIND_WRITE, 15, 15, word_t'(QMIN), 0, 0));
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0));
        send_item(mk(KIND_READ, 15, 15, 0, 0, 0));
        // plain 2x2 sweep over both pivots
        send_item(mk(KIND_WRITE, 0, 0, word_t'(48'd2 << FRAC_BITS), 0, 0));
        send_item(mk(KIND_WRITE, 0, 1, word_t'(48'd1 << FRAC_BITS), 0, 0));
        send_item(mk(KIND_WRITE, 1, 0, word_t'(48'd1 << FRAC_BITS), 0, 0));
        send_item(mk(KIND_WRITE, 1, 1, word_t'(48'd3 << FRAC_BITS), 0, 0));
        send_item(mk(KIND_SWEEP, 0, 0, 0, 0, 0));
        send_item(mk(KIND_SWEEP, 0, 0, 0, 1, 1));
        send_item(mk(KIND_READ, 0, 0, 0, 0, 0));
        send_item(mk(KIND_READ, 0, 1, 0, 0, 0));
        // pivot beyond the order: refused, then sticky error skips the rest of the list
        send_item(mk(KIND_SWEEP, 0, 0, 0, 3, 0));
        send_item(mk(KIND_SWEEP, 0, 0, 0, 0, 1));
        // pivot exactly at the threshold
        send_item(mk(KIND_WRITE, 0, 0, word_t'(1), 0, 0));
        send_item(mk(KIND_SWEEP, 0, 0, 0, 0, 1));
        // tiny pivot against a full-scale row: quotient saturates
        send_item(mk(KIND_WRITE, 0, 0, word_t'(2), 0, 0));
        send_item(mk(KIND_WRITE, 0, 1, word_t'(QMAX), 0, 0));
        send_item(mk(KIND_SWEEP, 0, 0, 0, 0, 1));
        send_item(mk(KIND_READ, 0, 1, 0, 0, 0));
        send_item(mk(KIND_READ, 1, 1, 0, 0, 0));
        // unused kind
        send_item(mk(KIND_UNUSED, 5, 5, word_t'(QMAX), 5, 1));

        // Random phases across orders and thresholds
        while (item_count < ITEM_GOAL)
        begin
            order = (phase_count < orders.size()) ? orders[phase_count]
                                                  : $urandom_range(1, 5);
            case ($urandom_range(0, 4))
                0: thr = '0;
                1: thr = THR_W'(1);
                2: thr = THR_W'(1) << FRAC_BITS;
                3: thr = {THR_W{1'b1}};
                default: thr = THR_W'($urandom_range(0, 24'hFFFFFF));
            endcase
            run_phase(order, thr, (eff_order(order) >= 8) ? 30 : 90);
        end
        drain();

        $display("run: %0d phases, %0d items, %0d sweeps (%0d with error), %0d reads",
                 phase_count, item_count, sb.sweeps, sb.refusals, sb.reads);
        if (sb.fails == 0)
            $display("matrix_sweep_engine_core: match");
        else
            $display("matrix_sweep_engine_core: mismatch");
        $finish;
    end

endmodule
